// ----- src/ppu_pkg.sv -----
// Shared types and constants for the permutation parity unit.
package ppu_pkg;

	localparam int TILE_W = 5;

	typedef struct packed {
		logic done;
		logic bad;
		logic blank_odd;
	} load_sum_t;

	typedef struct packed {
		logic done;
		logic odd;
	} walk_res_t;

	localparam logic [1:0] WALK_IDLE = 2'd0;
	localparam logic [1:0] WALK_SCAN = 2'd1;
	localparam logic [1:0] WALK_STEP = 2'd2;

endpackage

// ----- src/permutation_parity_unit.sv -----
// Top level of the permutation parity unit: loader, board RAM, cycle walker, result register.
//
// Channel   Dir  Per item           Fields (tdata, low bit up)
// s_axis    in   one board tile     tile_value[4:0], zero pad [7:5]
// m_axis    out  one result a board parity[0], invalid[1], zero pad [7:2]
//
// Tiles load in order, one per accepted beat; the last tile closes the board.
// A valid board is then walked through the single RAM read port: each start position is
// scanned in turn and every unvisited one has its permutation cycle followed tile by tile.
// A board with a repeated or out-of-range tile skips the walk.
// s_axis_tready is low from the last tile until the result enters the output register;
// a stalled result holds there while the next board loads. Reset clears all control state.
module permutation_parity_unit #(
	parameter int NUM_TILES = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // tile_value[4:0], pad [7:5]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // parity[0], invalid[1], pad [7:2]
);

	localparam int PW = $clog2(NUM_TILES);

	logic                       take;
	logic                       wr_en;
	logic [PW-1:0]              wr_addr;
	logic [PW-1:0]              rd_addr;
	logic [ppu_pkg::TILE_W-1:0] rd_data;
	ppu_pkg::load_sum_t         sum;
	ppu_pkg::walk_res_t         res;
	logic                       busy_q;
	logic                       pend_q;
	logic                       pend_par_q;
	logic                       pend_inv_q;
	logic                       out_valid_q;
	logic                       out_par_q;
	logic                       out_inv_q;

	assign s_axis_tready = !busy_q;
	assign take = s_axis_tvalid && s_axis_tready;

	ppu_load #(.NUM_TILES(NUM_TILES)) u_load (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.tile    (s_axis_tdata[ppu_pkg::TILE_W-1:0]),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.sum     (sum)
	);

	ppu_ram #(.WIDTH(ppu_pkg::TILE_W), .DEPTH(NUM_TILES)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (s_axis_tdata[ppu_pkg::TILE_W-1:0]),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ppu_walk #(.NUM_TILES(NUM_TILES)) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (sum.done && !sum.bad),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			pend_par_q <= 1'b0;
			pend_inv_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_par_q <= 1'b0;
			out_inv_q <= 1'b0;
		end else begin
			if (take && !busy_q && wr_addr == PW'(NUM_TILES - 1)) begin
				busy_q <= 1'b1;
			end
			if (sum.done && sum.bad) begin
				pend_q <= 1'b1;
				pend_par_q <= 1'b0;
				pend_inv_q <= 1'b1;
			end else if (res.done) begin
				pend_q <= 1'b1;
				pend_par_q <= res.odd ^ sum.blank_odd;
				pend_inv_q <= 1'b0;
			end
			if (pend_q && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
				out_par_q <= pend_par_q;
				out_inv_q <= pend_inv_q;
				pend_q <= 1'b0;
				busy_q <= 1'b0;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, out_inv_q, out_par_q};

endmodule

// ----- src/ppu_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ppu_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/ppu_load.sv -----
// Board loader: position counter, duplicate check and blank position.
module ppu_load #(
	parameter int NUM_TILES = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [ppu_pkg::TILE_W-1:0]   tile,
	output logic                         wr_en,
	output logic [$clog2(NUM_TILES)-1:0] wr_addr,
	output ppu_pkg::load_sum_t           sum
);

	localparam int PW = $clog2(NUM_TILES);

	logic [PW-1:0]        cnt_q;
	logic [NUM_TILES-1:0] seen_q;
	logic                 bad_q;
	logic                 blank_odd_q;
	ppu_pkg::load_sum_t   sum_q;
	logic                 in_range;
	logic [PW-1:0]        tile_idx;
	logic                 dup;
	logic                 last;
	logic                 blank_odd_next;

	assign in_range = int'(tile) < NUM_TILES;
	assign tile_idx = PW'(tile);
	assign dup = in_range && seen_q[tile_idx];
	assign last = cnt_q == PW'(NUM_TILES - 1);
	assign blank_odd_next = (in_range && tile == '0) ? cnt_q[0] : blank_odd_q;

	assign wr_en = take && in_range;
	assign wr_addr = cnt_q;
	assign sum = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seen_q <= '0;
			bad_q <= 1'b0;
			blank_odd_q <= 1'b0;
			sum_q <= '0;
		end else begin
			sum_q.done <= take && last;
			if (take) begin
				if (last) begin
					cnt_q <= '0;
					seen_q <= '0;
					bad_q <= 1'b0;
					blank_odd_q <= 1'b0;
					sum_q.bad <= bad_q || !in_range || dup;
					sum_q.blank_odd <= blank_odd_next;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (in_range) begin
						seen_q[tile_idx] <= 1'b1;
					end
					bad_q <= bad_q || !in_range || dup;
					blank_odd_q <= blank_odd_next;
				end
			end
		end
	end

endmodule

// ----- src/ppu_walk.sv -----
// Cycle walker: follows each permutation cycle through the board RAM.
module ppu_walk #(
	parameter int NUM_TILES = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	output logic [$clog2(NUM_TILES)-1:0] rd_addr,
	input  logic [ppu_pkg::TILE_W-1:0]   rd_data,
	output ppu_pkg::walk_res_t           res
);

	localparam int   PW    = $clog2(NUM_TILES);
	localparam logic N_ODD = (NUM_TILES % 2) == 1;

	logic [1:0]           state_q;
	logic [PW-1:0]        start_q;
	logic [NUM_TILES-1:0] visited_q;
	logic                 par_q;
	logic                 done_q;
	logic [PW-1:0]        step_pos;
	logic                 start_last;
	logic                 walk_end;

	assign step_pos = PW'(rd_data);
	assign start_last = start_q == PW'(NUM_TILES - 1);
	assign walk_end = start_last &&
		((state_q == ppu_pkg::WALK_SCAN && visited_q[start_q]) ||
		(state_q == ppu_pkg::WALK_STEP && step_pos == start_q));
	assign rd_addr = (state_q == ppu_pkg::WALK_STEP) ? step_pos : start_q;
	assign res.done = done_q;
	assign res.odd = par_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppu_pkg::WALK_IDLE;
			start_q <= '0;
			visited_q <= '0;
			par_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= walk_end;
			case (state_q)
				ppu_pkg::WALK_IDLE: begin
					if (go) begin
						start_q <= '0;
						visited_q <= '0;
						par_q <= N_ODD;
						state_q <= ppu_pkg::WALK_SCAN;
					end
				end
				ppu_pkg::WALK_SCAN: begin
					if (visited_q[start_q]) begin
						if (start_last) begin
							state_q <= ppu_pkg::WALK_IDLE;
						end else begin
							start_q <= start_q + 1'b1;
						end
					end else begin
						visited_q[start_q] <= 1'b1;
						state_q <= ppu_pkg::WALK_STEP;
					end
				end
				ppu_pkg::WALK_STEP: begin
					if (step_pos == start_q) begin
						par_q <= ~par_q;
						if (start_last) begin
							state_q <= ppu_pkg::WALK_IDLE;
						end else begin
							start_q <= start_q + 1'b1;
							state_q <= ppu_pkg::WALK_SCAN;
						end
					end else begin
						visited_q[step_pos] <= 1'b1;
					end
				end
				default: begin
					state_q <= ppu_pkg::WALK_IDLE;
				end
			endcase
		end
	end

endmodule
